FILE: rtl/slr_pkg.sv
// ----------------------------------------------------------------------------
// slr_pkg - shared types and constants of the stepper level regulator
// Item layouts, scaling constants and the exact divide-by-full-scale helper.
// ----------------------------------------------------------------------------
package slr_pkg;

	// Full-scale code of the converters and the spans that samples map onto.
	localparam int unsigned ADC_W        = 12;
	localparam int unsigned ADC_FULL     = 12'hFFF;
	localparam int unsigned LEVEL_SPAN   = 300;
	localparam int unsigned BAND_SPAN    = 40;
	localparam int unsigned BAND_MIN     = 10;
	localparam int unsigned BAND_RESET   = 25;
	localparam int unsigned AVG_SAMPLES_DEF = 4;

	// Field widths of the result item.
	localparam int unsigned LEVEL_W = 9;
	localparam int unsigned BAND_W  = 6;
	localparam int unsigned PHASE_W = 4;
	localparam int unsigned PROD_W  = 21;

	// Stepper phase end points.
	localparam logic [PHASE_W-1:0] PHASE_TOP    = 4'h8;
	localparam logic [PHASE_W-1:0] PHASE_BOTTOM = 4'h1;
	localparam logic [PHASE_W-1:0] PHASE_OFF    = 4'h0;

	// Indicator codes.
	localparam logic [1:0] IND_NONE  = 2'd0;
	localparam logic [1:0] IND_RED   = 2'd1;
	localparam logic [1:0] IND_GREEN = 2'd2;
	localparam logic [1:0] IND_BLUE  = 2'd3;

	// Mode codes.
	localparam logic MODE_TARGET = 1'b0;
	localparam logic MODE_BAND   = 1'b1;

	typedef struct packed {
		logic              button_down;
		logic              setting_valid;
		logic [ADC_W-1:0]  setting_sample;
		logic              level_valid;
		logic [ADC_W-1:0]  level_sample;
	} tick_t;

	typedef struct packed {
		logic               adjust_mode;
		logic [BAND_W-1:0]  band_width;
		logic [LEVEL_W-1:0] target_level;
		logic [LEVEL_W-1:0] average_level;
		logic [1:0]         indicator;
		logic [PHASE_W-1:0] motor_phase;
		logic               control_step;
	} result_t;

	// A tick item after scaling, held in the input stage.
	typedef struct packed {
		logic               button_down;
		logic               setting_valid;
		logic [BAND_W-1:0]  band_new;
		logic [LEVEL_W-1:0] target_new;
		logic               level_valid;
		logic [LEVEL_W-1:0] level_scaled;
	} scaled_t;

	// Exact floor(span * s / 4095) for spans up to a few hundred. The quotient
	// q of x / (4096 - 1) equals (x + (x >> 12) + 1) >> 12 while q stays small.
	function automatic logic [LEVEL_W-1:0] scale_full(input logic [ADC_W-1:0] s,
	                                                 input logic [LEVEL_W-1:0] span);
		logic [PROD_W-1:0] x;
		logic [PROD_W-1:0] t;
		x = PROD_W'(span) * PROD_W'(s);
		t = x + (x >> ADC_W) + PROD_W'(1);
		return t[ADC_W +: LEVEL_W];
	endfunction

endpackage

FILE: rtl/slr_tick_if.sv
// ----------------------------------------------------------------------------
// slr_tick_if - tick item channel
// Valid/ready channel carrying one tick of button and converter inputs.
// ----------------------------------------------------------------------------
interface slr_tick_if
	import slr_pkg::*;
();
	logic  valid;
	logic  ready;
	tick_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/slr_result_if.sv
// ----------------------------------------------------------------------------
// slr_result_if - result item channel
// Valid/ready channel carrying the regulator status after each tick.
// ----------------------------------------------------------------------------
interface slr_result_if
	import slr_pkg::*;
();
	logic    valid;
	logic    ready;
	result_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/stepper_level_regulator_core.sv
// ----------------------------------------------------------------------------
// stepper_level_regulator_core - water level regulator with stepper drive
// Mode button, band and target setting, four-sample level averaging and
// the red/green/blue band decision with one-hot phase stepping.
//
//  Channel  Direction  Contents
//  tick     sink       button, setting sample, level sample (with valids)
//  result   source     mode, band, target, mean, indicator, phase, step flag
//
// One tick item is taken per cycle while the result side does not stall; its
// result is presented from the result register, which follows the input stage.
// The item rate is set by the state update loop.
// Reset: band adjust mode, band 25, target, mean, phase and indicator zero.
// A stalled result register holds the input stage, which then stops taking
// items; no item is dropped or repeated.
// ----------------------------------------------------------------------------
module stepper_level_regulator_core
	import slr_pkg::*;
#(
	parameter int unsigned AVG_SAMPLES = AVG_SAMPLES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	slr_tick_if.sink    tick,
	slr_result_if.source result
);

	logic    valid_s1;
	logic    take;
	scaled_t item_s1;

	// Input capture and sample scaling.
	slr_scale u_scale (
		.clk      (clk),
		.arst_n   (arst_n),
		.tick     (tick),
		.take     (take),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	// State, decision and result register.
	slr_control #(
		.AVG_SAMPLES (AVG_SAMPLES)
	) u_control (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1),
		.take     (take),
		.result   (result)
	);

endmodule

FILE: rtl/slr_scale.sv
// ----------------------------------------------------------------------------
// slr_scale - input stage
// Takes tick items, scales both converter samples and holds the result for
// the control stage.
// ----------------------------------------------------------------------------
module slr_scale
	import slr_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	slr_tick_if.sink    tick,
	input  logic        take,
	output logic        valid_s1,
	output scaled_t     item_s1
);

	scaled_t item_d;

	// The stage frees up whenever its item moves on.
	assign tick.ready = !valid_s1 || take;

	// Scaling depends only on the sample, so it is done as the item is taken.
	always_comb begin
		item_d.button_down   = tick.data.button_down;
		item_d.setting_valid = tick.data.setting_valid;
		item_d.band_new      = BAND_W'(scale_full(tick.data.setting_sample,
		                                         LEVEL_W'(BAND_SPAN)) + LEVEL_W'(BAND_MIN));
		item_d.target_new    = scale_full(tick.data.setting_sample, LEVEL_W'(LEVEL_SPAN));
		item_d.level_valid   = tick.data.level_valid;
		item_d.level_scaled  = scale_full(tick.data.level_sample, LEVEL_W'(LEVEL_SPAN));
	end

	// Stage valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (tick.ready) begin
			valid_s1 <= tick.valid;
		end
	end

	// Stage payload.
	always_ff @(posedge clk) begin
		if (tick.valid && tick.ready) begin
			item_s1 <= item_d;
		end
	end

endmodule

FILE: rtl/slr_control.sv
// ----------------------------------------------------------------------------
// slr_control - regulator state and decision
// Updates mode, band, target and the sample group, runs the band decision
// on the last sample of a group and registers the result item.
// ----------------------------------------------------------------------------
module slr_control
	import slr_pkg::*;
#(
	parameter int unsigned AVG_SAMPLES = AVG_SAMPLES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        valid_s1,
	input  scaled_t     item_s1,
	output logic        take,
	slr_result_if.source result
);

	localparam int unsigned SUM_MAX = LEVEL_SPAN * AVG_SAMPLES;
	localparam int unsigned SUM_W   = $clog2(SUM_MAX + 1);
	localparam int unsigned CNT_W   = $clog2(AVG_SAMPLES);
	// Reciprocal exact for every group sum: 2**DIV_SH exceeds (SUM_MAX+1)*N.
	localparam int unsigned DIV_SH  = $clog2((SUM_MAX + 1) * AVG_SAMPLES) + 1;
	localparam int unsigned RECIP   = ((2 ** DIV_SH) + AVG_SAMPLES - 1) / AVG_SAMPLES;
	localparam int unsigned MUL_W   = SUM_W + DIV_SH;
	localparam int unsigned CMP_W   = LEVEL_W + 1;

	logic               mode_q;
	logic               held_q;
	logic [BAND_W-1:0]  band_q;
	logic [LEVEL_W-1:0] target_q;
	logic [SUM_W-1:0]   sum_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [LEVEL_W-1:0] avg_q;
	logic [PHASE_W-1:0] phase_q;
	logic [1:0]         ind_q;

	logic               mode_d;
	logic [BAND_W-1:0]  band_d;
	logic [LEVEL_W-1:0] target_d;
	logic [SUM_W-1:0]   total;
	logic [MUL_W-1:0]   prod;
	logic [LEVEL_W-1:0] mean;
	logic [CMP_W-1:0]   mean_plus_band;
	logic [CMP_W-1:0]   target_plus_band;
	logic               last;
	logic               decide;
	logic [LEVEL_W-1:0] avg_d;
	logic [PHASE_W-1:0] phase_d;
	logic [1:0]         ind_d;
	logic               out_valid_q;
	result_t            out_q;

	// The item moves on when the result register is free or being emptied.
	assign take = valid_s1 && (!out_valid_q || result.ready);

	// Mode toggles on the press edge; the setting sample then uses the new mode.
	always_comb begin
		mode_d   = (item_s1.button_down && !held_q) ? !mode_q : mode_q;
		band_d   = band_q;
		target_d = target_q;
		if (item_s1.setting_valid) begin
			if (mode_d == MODE_BAND) begin
				band_d = item_s1.band_new;
			end else begin
				target_d = item_s1.target_new;
			end
		end
	end

	// Group sum and its mean by reciprocal multiplication.
	assign total  = sum_q + SUM_W'(item_s1.level_scaled);
	assign prod   = MUL_W'(total) * MUL_W'(RECIP);
	assign mean   = prod[DIV_SH +: LEVEL_W];
	assign last   = (cnt_q == CNT_W'(AVG_SAMPLES - 1));
	assign decide = item_s1.level_valid && last;

	// Band test without signed values: mean < target - band becomes
	// mean + band < target.
	assign mean_plus_band   = CMP_W'(mean) + CMP_W'(band_d);
	assign target_plus_band = CMP_W'(target_d) + CMP_W'(band_d);

	always_comb begin
		avg_d   = avg_q;
		phase_d = phase_q;
		ind_d   = ind_q;
		if (decide) begin
			avg_d = mean;
			if (mean_plus_band < CMP_W'(target_d)) begin
				ind_d = IND_RED;
				if (phase_q == PHASE_OFF || phase_q == PHASE_TOP) begin
					phase_d = PHASE_BOTTOM;
				end else begin
					phase_d = phase_q << 1;
				end
			end else if (CMP_W'(mean) <= target_plus_band) begin
				ind_d   = IND_GREEN;
				phase_d = PHASE_OFF;
			end else begin
				ind_d = IND_BLUE;
				if (phase_q == PHASE_OFF || phase_q == PHASE_BOTTOM) begin
					phase_d = PHASE_TOP;
				end else begin
					phase_d = phase_q >> 1;
				end
			end
		end
	end

	// Regulator state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_BAND;
			held_q   <= 1'b0;
			band_q   <= BAND_W'(BAND_RESET);
			target_q <= '0;
			sum_q    <= '0;
			cnt_q    <= '0;
			avg_q    <= '0;
			phase_q  <= PHASE_OFF;
			ind_q    <= IND_NONE;
		end else if (take) begin
			mode_q   <= mode_d;
			held_q   <= item_s1.button_down;
			band_q   <= band_d;
			target_q <= target_d;
			avg_q    <= avg_d;
			phase_q  <= phase_d;
			ind_q    <= ind_d;
			if (item_s1.level_valid) begin
				if (last) begin
					sum_q <= '0;
					cnt_q <= '0;
				end else begin
					sum_q <= total;
					cnt_q <= cnt_q + CNT_W'(1);
				end
			end
		end
	end

	// Result register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result register payload: the state after the tick.
	always_ff @(posedge clk) begin
		if (take) begin
			out_q.adjust_mode   <= mode_d;
			out_q.band_width    <= band_d;
			out_q.target_level  <= target_d;
			out_q.average_level <= avg_d;
			out_q.indicator     <= ind_d;
			out_q.motor_phase   <= phase_d;
			out_q.control_step  <= decide;
		end
	end

	assign result.valid = out_valid_q;
	assign result.data  = out_q;

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top - regression bench for the stepper level regulator core
// Drives tick items through the valid/ready channel in bursts of random
// length while the result side stalls on its own pattern. A tracker class
// mirrors the mode, setting, averaging and phase logic for every accepted
// item and compares each status item from the core field by field.
// ----------------------------------------------------------------------------
module tb_top;
	import slr_pkg::*;

	localparam int unsigned RANDOM_ITEMS = 850;
	localparam int unsigned STALL_LIMIT  = 2000;
	localparam int unsigned LONG_HOLD    = 150;
	localparam int unsigned TAIL_CYCLES  = 8;

	// Tracks the regulator state and holds the statuses still to arrive.
	class regulator_tracker;
		logic               mode;
		logic               button_latched;
		logic [BAND_W-1:0]  band;
		logic [LEVEL_W-1:0] target;
		logic [LEVEL_W-1:0] level_group [AVG_SAMPLES_DEF];
		int unsigned        group_fill;
		logic [LEVEL_W-1:0] mean;
		logic [1:0]         lamp;
		logic [PHASE_W-1:0] phase;
		result_t            due_status [$];
		int unsigned        mismatches;

		function new();
			mode           = MODE_BAND;
			button_latched = 1'b0;
			band           = BAND_W'(BAND_RESET);
			target         = '0;
			group_fill     = 0;
			mean           = '0;
			lamp           = IND_NONE;
			phase          = PHASE_OFF;
			mismatches     = 0;
		endfunction

		// Exact floor of span * code / full scale.
		function int unsigned scale_code(logic [ADC_W-1:0] code, int unsigned span);
			return (span * int'(code)) / ADC_FULL;
		endfunction

		function int unsigned due_count();
			return due_status.size();
		endfunction

		// Works out the status that one accepted tick item leads to.
		function void note_tick(tick_t item);
			result_t     status;
			int unsigned total;
			int          low_edge;
			int          high_edge;
			logic        stepped;
			stepped = 1'b0;

			// The mode flips only on the press edge of the button.
			if (item.button_down && !button_latched) begin
				mode           = ~mode;
				button_latched = 1'b1;
			end else if (!item.button_down) begin
				button_latched = 1'b0;
			end

			// A setting sample goes to whichever value the new mode adjusts.
			if (item.setting_valid) begin
				if (mode == MODE_BAND) begin
					band = BAND_W'(scale_code(item.setting_sample, BAND_SPAN) + BAND_MIN);
				end else begin
					target = LEVEL_W'(scale_code(item.setting_sample, LEVEL_SPAN));
				end
			end

			// Level samples fill the group; a full group runs the decision.
			if (item.level_valid) begin
				level_group[group_fill] = LEVEL_W'(scale_code(item.level_sample, LEVEL_SPAN));
				group_fill++;
				if (group_fill == AVG_SAMPLES_DEF) begin
					total = 0;
					foreach (level_group[i]) begin
						total += level_group[i];
					end
					mean      = LEVEL_W'(total / AVG_SAMPLES_DEF);
					low_edge  = int'(target) - int'(band);
					high_edge = int'(target) + int'(band);
					if (int'(mean) < low_edge) begin
						lamp  = IND_RED;
						phase = (phase == PHASE_OFF || phase == PHASE_TOP) ?
							PHASE_BOTTOM : PHASE_W'(phase << 1);
					end else if (int'(mean) <= high_edge) begin
						lamp  = IND_GREEN;
						phase = PHASE_OFF;
					end else begin
						lamp  = IND_BLUE;
						phase = (phase == PHASE_OFF || phase == PHASE_BOTTOM) ?
							PHASE_TOP : PHASE_W'(phase >> 1);
					end
					group_fill = 0;
					stepped    = 1'b1;
				end
			end

			status.adjust_mode   = mode;
			status.band_width    = band;
			status.target_level  = target;
			status.average_level = mean;
			status.indicator     = lamp;
			status.motor_phase   = phase;
			status.control_step  = stepped;
			due_status.push_back(status);
		endfunction

		function void compare_field(string field, logic [31:0] want, logic [31:0] got);
			if (got !== want) begin
				$error("%s: expected %0d, actual %0d", field, want, got);
				mismatches++;
			end
		endfunction

		// Compares one status item from the core with the oldest one due.
		function void check_status(result_t got);
			result_t want;
			if (due_status.size() == 0) begin
				$error("status item arrived with none due: %p", got);
				mismatches++;
				return;
			end
			want = due_status.pop_front();
			compare_field("adjust_mode", 32'(want.adjust_mode), 32'(got.adjust_mode));
			compare_field("band_width", 32'(want.band_width), 32'(got.band_width));
			compare_field("target_level", 32'(want.target_level), 32'(got.target_level));
			compare_field("average_level", 32'(want.average_level), 32'(got.average_level));
			compare_field("indicator", 32'(want.indicator), 32'(got.indicator));
			compare_field("motor_phase", 32'(want.motor_phase), 32'(got.motor_phase));
			compare_field("control_step", 32'(want.control_step), 32'(got.control_step));
		endfunction
	endclass

	logic clk;
	logic arst_n;
	bit   hold_off_due;
	int unsigned burst_left;
	int unsigned quiet_cycles;
	regulator_tracker tracker;

	slr_tick_if   tick_ch ();
	slr_result_if result_ch ();

	stepper_level_regulator_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.tick   (tick_ch),
		.result (result_ch)
	);

	// 10 ns clock.
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Both channels are observed on the values held just before each edge.
	// The same process watches for a run that has stopped making progress.
	always @(posedge clk) begin
		if (arst_n) begin
			if (tick_ch.valid && tick_ch.ready) begin
				tracker.note_tick(tick_ch.data);
			end
			if (result_ch.valid && result_ch.ready) begin
				tracker.check_status(result_ch.data);
			end
			if ((tick_ch.valid && tick_ch.ready) || (result_ch.valid && result_ch.ready)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
			end
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("Regression FAIL");
				$finish;
			end
		end
	end

	// Result side: stretches of differing stall patterns, and one long
	// hold-off on request while the sender keeps offering items.
	initial begin : receiver
		int unsigned style;
		int unsigned stretch;
		result_ch.ready = 1'b0;
		while (!arst_n) begin
			@(posedge clk);
		end
		forever begin
			if (hold_off_due) begin
				hold_off_due = 1'b0;
				result_ch.ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
			end
			style   = $urandom_range(0, 3);
			stretch = $urandom_range(20, 120);
			for (int n = 0; n < stretch; n++) begin
				case (style)
					0: begin
						result_ch.ready <= 1'b1;
					end
					1: begin
						result_ch.ready <= 1'($urandom_range(0, 1));
					end
					2: begin
						result_ch.ready <= (n % 5) != 4;
					end
					default: begin
						result_ch.ready <= ($urandom_range(0, 3) == 0);
					end
				endcase
				@(posedge clk);
			end
		end
	end

	function automatic tick_t make_tick(logic button, logic set_v, logic [ADC_W-1:0] set_s,
	                                    logic lev_v, logic [ADC_W-1:0] lev_s);
		tick_t item;
		item.button_down    = button;
		item.setting_valid  = set_v;
		item.setting_sample = set_s;
		item.level_valid    = lev_v;
		item.level_sample   = lev_s;
		return item;
	endfunction

	// Offers one item and returns once it has been taken. Items go out in
	// bursts; between bursts the valid line may drop for a random gap.
	task automatic drive_item(input tick_t item);
		int unsigned gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap != 0) begin
				tick_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		tick_ch.valid <= 1'b1;
		tick_ch.data  <= item;
		do begin
			@(posedge clk);
		end while (!tick_ch.ready);
	endtask

	// A full group of level samples, with an optional setting on the first.
	task automatic drive_group(input logic set_v, input logic [ADC_W-1:0] set_s,
	                           input logic [ADC_W-1:0] lev_s);
		drive_item(make_tick(1'b0, set_v, set_s, 1'b1, lev_s));
		for (int k = 1; k < AVG_SAMPLES_DEF; k++) begin
			drive_item(make_tick(1'b0, 1'b0, '0, 1'b1, lev_s));
		end
	endtask

	task automatic drain_results();
		tick_ch.valid <= 1'b0;
		do begin
			@(posedge clk);
		end while (tracker.due_count() != 0);
	endtask

	initial begin : stimulus
		logic [ADC_W-1:0] full_code;
		logic             button_state;
		int               centre;
		int               level_code;
		tick_t            item;
		full_code       = ADC_W'(ADC_FULL);
		button_state    = 1'b0;
		centre          = 2048;
		hold_off_due    = 1'b0;
		burst_left      = 0;
		quiet_cycles    = 0;
		tracker         = new();
		arst_n          = 1'b0;
		tick_ch.valid   = 1'b0;
		tick_ch.data    = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Idle tick, then the band at both ends of the setting range.
		drive_item(make_tick(1'b0, 1'b0, '0, 1'b0, '0));
		drive_item(make_tick(1'b0, 1'b1, full_code, 1'b0, '0));
		drive_item(make_tick(1'b0, 1'b1, '0, 1'b0, '0));
		// Press edge and a setting in the same item: the target takes it.
		// The held button must not toggle again; the group ends red from 0.
		drive_item(make_tick(1'b1, 1'b1, full_code, 1'b1, '0));
		drive_item(make_tick(1'b1, 1'b0, '0, 1'b1, '0));
		drive_item(make_tick(1'b0, 1'b0, '0, 1'b1, '0));
		drive_item(make_tick(1'b0, 1'b0, '0, 1'b1, '0));
		// Blue from the bottom phase, red from the top phase, green with the
		// lower band edge below zero, then blue from zero and halving.
		drive_group(1'b1, '0, full_code);
		drive_group(1'b1, full_code, '0);
		drive_group(1'b1, '0, '0);
		drive_group(1'b0, '0, full_code);
		drive_group(1'b0, '0, full_code);

		// Random part: level samples mostly cluster around a drifting centre
		// so that runs of the same decision rotate the phase repeatedly.
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i == 100) begin
				hold_off_due = 1'b1;
			end
			if (i == 500) begin
				drain_results();
			end
			if ($urandom_range(0, 4) == 0) begin
				button_state = ~button_state;
			end
			if ($urandom_range(0, 19) == 0) begin
				if ($urandom_range(0, 3) == 0) begin
					centre = ($urandom_range(0, 1) == 0) ? 0 : int'(ADC_FULL);
				end else begin
					centre = int'($urandom_range(0, ADC_FULL));
				end
			end
			if ($urandom_range(0, 3) == 0) begin
				level_code = int'($urandom_range(0, ADC_FULL));
			end else begin
				level_code = centre + int'($urandom_range(0, 300)) - 150;
				if (level_code < 0) begin
					level_code = 0;
				end else if (level_code > int'(ADC_FULL)) begin
					level_code = int'(ADC_FULL);
				end
			end
			item.button_down   = button_state;
			item.setting_valid = ($urandom_range(0, 2) == 0);
			if ($urandom_range(0, 7) == 0) begin
				item.setting_sample = ($urandom_range(0, 1) == 0) ? '0 : full_code;
			end else begin
				item.setting_sample = ADC_W'($urandom_range(0, ADC_FULL));
			end
			item.level_valid  = ($urandom_range(0, 3) != 0);
			item.level_sample = ADC_W'(level_code);
			drive_item(item);
		end

		drain_results();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (tracker.mismatches == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
